### rtl/core/scr_pkg.sv
package scr_pkg;

    // Default width of the millisecond time base.
    localparam int TIME_BITS_DEF = 32;

    // Width of the divisor and remainder in the shared divider.
    localparam int DIVISOR_W = 16;

    // Reset value of the simulated repetition period in milliseconds.
    localparam logic [15:0] PERIOD_RESET = 16'd2000;

    // Item function codes.
    localparam logic [1:0] FUNC_UPDATE = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_RESET  = 2'd2;

    // Trigger source modes; the remaining codes behave as the external counter.
    localparam logic [1:0] MODE_SIM    = 2'd0;
    localparam logic [1:0] MODE_SERIAL = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_PERIOD  = 2'd1;
    localparam logic [1:0] REG_SLICES  = 2'd2;
    localparam logic [1:0] REG_TRIGGER = 2'd3;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/core/scr_div.sv
module scr_div #(
    parameter int DVD_W = scr_pkg::TIME_BITS_DEF + 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [DVD_W-1:0]             dividend,
    input  logic [scr_pkg::DIVISOR_W-1:0] divisor,
    output scr_pkg::div_status_t         status,
    output logic [DVD_W-1:0]             quotient,
    output logic [scr_pkg::DIVISOR_W-1:0] remainder
);

    localparam int DSR_W = scr_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   rem_sub;
    logic             ge;

    // One restoring step per cycle: shift in the next dividend bit, try to
    // subtract the divisor, and shift the quotient bit into the dividend word.
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign ge      = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = dvd_reg;
    assign remainder   = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == CNT_W'(DVD_W))
        else $error("divider did not load on start");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty step count");

endmodule

### rtl/core/scan_repetition_counter.sv
// Channel   Direction  Signals                          Content
// s_        in         s_tvalid s_tready s_tdata s_tuser one command item
// m_        out        m_tvalid m_tready m_tdata m_tuser one result per item
// cfg_      in         cfg_valid cfg_ready cfg_index    register write
//                      cfg_data
//
// An item is taken only in the idle state. Start, reset, no-op and most updates
// pass through idle with the transfer, evaluate, then finish. A serial slice
// update runs the shared restoring divider over TIME_BITS + 8 steps; a
// simulated-mode slice update adds a multiply step before the divider.
// The result sits in an output register, so the next item is taken while it
// waits; a held result only delays the finish of the following item.
// Reset clears all counters and the start and zero timestamps; the period register resets to
// 2000 ms. Configuration writes are accepted in every cycle.
module scan_repetition_counter #(
    parameter int TIME_BITS = scr_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: now_time[31:0], byte_count[33:32], byte_first[41:34],
    // byte_second[49:42], ext_count[65:50], zero fill[71:66].
    input  logic [71:0] s_tdata,
    // From bit 0: func[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: rep_count[15:0], last_rep_len[47:16], slice_now[63:48].
    output logic [63:0] m_tdata,
    // From bit 0: new_rep[0].
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DW    = TIME_BITS + 8;
    localparam int DSR_W = scr_pkg::DIVISOR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [15:0] period_reg;
    logic [7:0]  spr_reg;
    logic [7:0]  trig_reg;

    // Block state.
    state_t               state_reg, state_next;
    logic                 running_reg, running_next;
    logic [TIME_BITS-1:0] rep_start_reg, rep_start_next;
    logic [TIME_BITS-1:0] zero_reg, zero_next;
    logic [15:0]          rep_num_reg, rep_num_next;
    logic [TIME_BITS-1:0] prev_len_reg, prev_len_next;
    logic [15:0]          slice_reg, slice_next;
    logic                 fired_reg, fired_next;
    logic                 serial_div_reg, serial_div_next;

    // Captured input item.
    logic [1:0]           func_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [1:0]           nb_reg;
    logic [7:0]           b0_reg;
    logic [7:0]           b1_reg;
    logic [15:0]          ext_reg;

    // Output register.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic [0:0]  m_tuser_reg, m_tuser_next;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] since_zero;
    logic [DW-1:0]        product;
    logic [15:0]          slice_val;
    logic [15:0]          slice_m1;
    logic                 sim_fire;

    logic                 div_start;
    logic [DW-1:0]        div_dividend;
    logic [DSR_W-1:0]     div_divisor;
    scr_pkg::div_status_t div_stat;
    logic [DW-1:0]        div_quo;
    logic [DSR_W-1:0]     div_rem;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    // Time stamps wrap at TIME_BITS; a narrower base drops the high bits.
    assign now_wide   = {32'd0, s_tdata[31:0]};
    assign elapsed    = now_reg - rep_start_reg;
    assign since_zero = now_reg - zero_reg;
    assign sim_fire   = (elapsed > TIME_BITS'(period_reg));

    // The simulated slice is floor(since_zero * slices / period); the product
    // is formed once and handed to the divider.
    assign product    = DW'(since_zero) * DW'(spr_reg);

    // Serial slice number, high byte first; a single byte leaves the low
    // byte at zero.
    assign slice_val  = {b0_reg, (nb_reg >= 2'd2) ? b1_reg : 8'd0};
    assign slice_m1   = slice_val - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= scr_pkg::MODE_SIM;
            period_reg <= scr_pkg::PERIOD_RESET;
            spr_reg    <= '0;
            trig_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scr_pkg::REG_MODE:    mode_reg   <= cfg_data[1:0];
                scr_pkg::REG_PERIOD:  period_reg <= cfg_data;
                scr_pkg::REG_SLICES:  spr_reg    <= cfg_data[7:0];
                scr_pkg::REG_TRIGGER: trig_reg   <= cfg_data[7:0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            now_reg  <= now_wide[TIME_BITS-1:0];
            nb_reg   <= s_tdata[33:32];
            b0_reg   <= s_tdata[41:34];
            b1_reg   <= s_tdata[49:42];
            ext_reg  <= s_tdata[65:50];
        end
    end

    // Divider launch: from the evaluate step for a serial slice, or from the
    // multiply step for a simulated slice.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DW'(slice_m1);
        div_divisor  = DSR_W'(spr_reg);
        if (state_reg == S_MUL)
        begin
            div_start    = 1'b1;
            div_dividend = product;
            div_divisor  = period_reg;
        end
        else if (state_reg == S_EVAL && func_reg == scr_pkg::FUNC_UPDATE
                 && running_reg && mode_reg == scr_pkg::MODE_SERIAL
                 && nb_reg != 2'd0 && spr_reg != 8'd0 && slice_val != 16'd0)
        begin
            div_start = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        rep_start_next  = rep_start_reg;
        zero_next       = zero_reg;
        rep_num_next    = rep_num_reg;
        prev_len_next   = prev_len_reg;
        slice_next      = slice_reg;
        fired_next      = fired_reg;
        serial_div_next = serial_div_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                    fired_next = 1'b0;
                end
            end
            S_EVAL:
            begin
                state_next = S_FIN;
                unique case (func_reg)
                    scr_pkg::FUNC_START:
                    begin
                        running_next   = 1'b1;
                        rep_start_next = now_reg;
                    end
                    scr_pkg::FUNC_RESET:
                    begin
                        zero_next     = now_reg;
                        rep_num_next  = '0;
                        prev_len_next = '0;
                        slice_next    = '0;
                    end
                    scr_pkg::FUNC_UPDATE:
                    begin
                        if (running_reg)
                        begin
                            unique case (mode_reg)
                                scr_pkg::MODE_SIM:
                                begin
                                    if (sim_fire)
                                    begin
                                        rep_num_next   = rep_num_reg + 16'd1;
                                        prev_len_next  = elapsed;
                                        rep_start_next = now_reg;
                                        fired_next     = 1'b1;
                                    end
                                    else if (spr_reg == 8'd0 || period_reg == 16'd0)
                                    begin
                                        slice_next = '0;
                                    end
                                    else
                                    begin
                                        serial_div_next = 1'b0;
                                        state_next      = S_MUL;
                                    end
                                end
                                scr_pkg::MODE_SERIAL:
                                begin
                                    if (div_start)
                                    begin
                                        serial_div_next = 1'b1;
                                        state_next      = S_DIV;
                                    end
                                    else if (nb_reg != 2'd0 && spr_reg == 8'd0
                                             && b0_reg == trig_reg)
                                    begin
                                        rep_num_next   = rep_num_reg + 16'd1;
                                        prev_len_next  = elapsed;
                                        rep_start_next = now_reg;
                                        fired_next     = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    if (ext_reg != rep_num_reg)
                                    begin
                                        rep_num_next   = ext_reg;
                                        prev_len_next  = elapsed;
                                        rep_start_next = now_reg;
                                        fired_next     = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        fired_next = 1'b0;
                    end
                endcase
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                    if (serial_div_reg)
                    begin
                        // Repetition number from the slice; a slice that opens
                        // a repetition leaves a zero remainder.
                        slice_next   = slice_val;
                        rep_num_next = div_quo[15:0] + 16'd1;
                        if (div_rem == '0)
                        begin
                            prev_len_next  = elapsed;
                            rep_start_next = now_reg;
                            fired_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        slice_next = div_quo[15:0];
                    end
                end
            end
            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = fired_reg;
                    m_tdata_next  = {slice_reg, 32'(prev_len_reg), rep_num_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= 1'b0;
            rep_start_reg  <= '0;
            zero_reg       <= '0;
            rep_num_reg    <= '0;
            prev_len_reg   <= '0;
            slice_reg      <= '0;
            fired_reg      <= 1'b0;
            serial_div_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            rep_start_reg  <= rep_start_next;
            zero_reg       <= zero_next;
            rep_num_reg    <= rep_num_next;
            prev_len_reg   <= prev_len_next;
            slice_reg      <= slice_next;
            fired_reg      <= fired_next;
            serial_div_reg <= serial_div_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    scr_div #(
        .DVD_W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_stat.busy)
        else $error("input ready while a division runs");

    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EVAL)
        else $error("accepted item not evaluated");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("division finished outside the divide step");

endmodule
